// ===== hw/rtl/crob_pkg.sv =====
// ----------------------------------------------------------------------------
// crob_pkg
// Shared types and constants of the clipped raster-op blitter.
// ----------------------------------------------------------------------------
package crob_pkg;

    // Default frame limits in pixels.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Width of the signed coordinate arithmetic used by clipping.
    localparam int CW = 14;

    // Field widths.
    localparam int COORD_W = 12;
    localparam int PIX_W   = 32;
    localparam int SIZE_W  = 9;
    localparam int IDX_W   = 2;

    // Command codes.
    localparam logic [1:0] CMD_WR_SRC = 2'd0;
    localparam logic [1:0] CMD_WR_DST = 2'd1;
    localparam logic [1:0] CMD_RD_DST = 2'd2;
    localparam logic [1:0] CMD_BLIT   = 2'd3;

    // Raster operations.
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_XOR   = 2'd1;
    localparam logic [1:0] MODE_BLEND = 2'd2;
    localparam logic [1:0] MODE_ALPHA = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEST_W = 2'd0;
    localparam logic [1:0] REG_DEST_H = 2'd1;
    localparam logic [1:0] REG_SRC_W  = 2'd2;
    localparam logic [1:0] REG_SRC_H  = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic cap;       // capture an input item and its clipped rectangle
        logic wr_pix;    // single pixel write
        logic rd_pix;    // single pixel read request
        logic cap_rd;    // capture single pixel read data
        logic rd_blit;   // blit: read source and destination pixel
        logic mul;       // blit: register pixels and blend products
        logic wr_blit;   // blit: write result and advance
        logic out_load;  // load the output register
    } t_ctl_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       last;
        logic       out_free;
    } t_ctl_sts;

endpackage

// ===== hw/rtl/crob_cmd_if.sv =====
// ----------------------------------------------------------------------------
// crob_cmd_if
// Command channel of the blitter: one command item per transfer.
// ----------------------------------------------------------------------------
interface crob_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [11:0] dest_x;
    logic signed [11:0] dest_y;
    logic signed [11:0] src_x;
    logic signed [11:0] src_y;
    logic signed [11:0] rect_width;
    logic signed [11:0] rect_height;
    logic [1:0]         blend_mode;
    logic [31:0]        pixel_in;

    modport source(output valid, cmd, dest_x, dest_y, src_x, src_y, rect_width,
                   rect_height, blend_mode, pixel_in, input ready);
    modport sink(input valid, cmd, dest_x, dest_y, src_x, src_y, rect_width,
                 rect_height, blend_mode, pixel_in, output ready);
endinterface

// ===== hw/rtl/crob_res_if.sv =====
// ----------------------------------------------------------------------------
// crob_res_if
// Result channel of the blitter: one result item per transfer.
// ----------------------------------------------------------------------------
interface crob_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic        ok;

    modport source(output valid, pixel_out, ok, input ready);
    modport sink(input valid, pixel_out, ok, output ready);
endinterface

// ===== hw/rtl/crob_cfg_if.sv =====
// ----------------------------------------------------------------------------
// crob_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface crob_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/crob_ram.sv =====
// ----------------------------------------------------------------------------
// crob_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/crob_ctrl.sv =====
// ----------------------------------------------------------------------------
// crob_ctrl
// Controller: sequences pixel accesses and the per-pixel blit walk.
// ----------------------------------------------------------------------------
module crob_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  crob_pkg::t_ctl_sts  i_sts,
    output crob_pkg::t_ctl_cmd  o_ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_PRD  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.cmd)
                    crob_pkg::CMD_WR_SRC,
                    crob_pkg::CMD_WR_DST: begin
                        o_ctl.wr_pix = 1'b1;
                        n_state      = S_DONE;
                    end
                    crob_pkg::CMD_RD_DST: begin
                        o_ctl.rd_pix = 1'b1;
                        n_state      = S_PRD;
                    end
                    default: begin
                        n_state = i_sts.empty ? S_DONE : S_RD;
                    end
                endcase
            end
            S_PRD: begin
                o_ctl.cap_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_RD: begin
                o_ctl.rd_blit = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                o_ctl.wr_blit = 1'b1;
                n_state       = i_sts.last ? S_DONE : S_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/crob_datapath.sv =====
// ----------------------------------------------------------------------------
// crob_datapath
// Datapath: size registers, clipping, frame stores, raster ops and output.
// ----------------------------------------------------------------------------
module crob_datapath #(
    parameter int MAX_WIDTH  = crob_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crob_pkg::DEF_MAX_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crob_pkg::t_ctl_cmd  i_ctl,
    output crob_pkg::t_ctl_sts  o_sts,
    input  logic [1:0]          i_cmd,
    input  logic signed [11:0]  i_dest_x,
    input  logic signed [11:0]  i_dest_y,
    input  logic signed [11:0]  i_src_x,
    input  logic signed [11:0]  i_src_y,
    input  logic signed [11:0]  i_rect_width,
    input  logic signed [11:0]  i_rect_height,
    input  logic [1:0]          i_blend_mode,
    input  logic [31:0]         i_pixel_in,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [31:0]         o_pixel_out,
    output logic                o_ok
);

    localparam int CW    = crob_pkg::CW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RDEP  = (DEPTH > 1) ? DEPTH : 2;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] h;
    } t_rect;

    // Negative sizes flip, negative origins shrink, far origins pin to the
    // last column or row, then the size is cut at the frame edge.
    function automatic t_rect clip(input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y,
                                   input logic signed [CW-1:0] w,
                                   input logic signed [CW-1:0] h,
                                   input logic signed [CW-1:0] fw,
                                   input logic signed [CW-1:0] fh);
        t_rect r;
        r.x = x;
        r.y = y;
        r.w = w;
        r.h = h;
        if (r.w < 0) begin
            r.x = r.x + r.w;
            r.w = -r.w;
        end
        if (r.h < 0) begin
            r.y = r.y + r.h;
            r.h = -r.h;
        end
        if (r.x < 0) begin
            r.w = r.w + r.x;
            if (r.w < 0) r.w = '0;
            r.x = '0;
        end
        if (r.y < 0) begin
            r.h = r.h + r.y;
            if (r.h < 0) r.h = '0;
            r.y = '0;
        end
        if (r.x >= fw) r.x = fw - CW'(1);
        if (r.y >= fh) r.y = fh - CW'(1);
        if (r.x + r.w > fw) r.w = fw - r.x;
        if (r.y + r.h > fh) r.h = fh - r.y;
        return r;
    endfunction

    function automatic logic [AW-1:0] mk_addr(input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y);
        logic [2*CW-1:0] full;
        full = (2*CW)'($unsigned(y)) * (2*CW)'(MAX_WIDTH) + (2*CW)'($unsigned(x));
        return full[AW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] eff(input logic [8:0] v,
                                                 input logic signed [CW-1:0] mx);
        if (v == '0) return CW'(1);
        if ($signed(CW'(v)) > mx) return mx;
        return $signed(CW'(v));
    endfunction

    // Size registers.
    logic [8:0] r_dw, r_dh, r_sw, r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw <= 9'd256;
            r_dh <= 9'd256;
            r_sw <= 9'd256;
            r_sh <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crob_pkg::REG_DEST_W: r_dw <= i_cfg_data;
                crob_pkg::REG_DEST_H: r_dh <= i_cfg_data;
                crob_pkg::REG_SRC_W:  r_sw <= i_cfg_data;
                crob_pkg::REG_SRC_H:  r_sh <= i_cfg_data;
                default:              r_dw <= r_dw;
            endcase
        end
    end

    logic signed [CW-1:0] w_dw, w_dh, w_sw, w_sh;
    assign w_dw = eff(r_dw, CW'(MAX_WIDTH));
    assign w_dh = eff(r_dh, CW'(MAX_HEIGHT));
    assign w_sw = eff(r_sw, CW'(MAX_WIDTH));
    assign w_sh = eff(r_sh, CW'(MAX_HEIGHT));

    // Input decode.
    logic signed [CW-1:0] w_dx, w_dy, w_sx, w_sy, w_rw, w_rh;
    assign w_dx = CW'(i_dest_x);
    assign w_dy = CW'(i_dest_y);
    assign w_sx = CW'(i_src_x);
    assign w_sy = CW'(i_src_y);
    assign w_rw = CW'(i_rect_width);
    assign w_rh = CW'(i_rect_height);

    t_rect w_sclip, w_dclip;
    assign w_sclip = clip(w_sx, w_sy, w_rw, w_rh, w_sw, w_sh);
    assign w_dclip = clip(w_dx, w_dy, w_rw, w_rh, w_dw, w_dh);

    logic                 w_is_src;
    logic signed [CW-1:0] w_px, w_py, w_pfw, w_pfh;
    logic                 w_pok;
    assign w_is_src = (i_cmd == crob_pkg::CMD_WR_SRC);
    assign w_px     = w_is_src ? w_sx : w_dx;
    assign w_py     = w_is_src ? w_sy : w_dy;
    assign w_pfw    = w_is_src ? w_sw : w_dw;
    assign w_pfh    = w_is_src ? w_sh : w_dh;
    assign w_pok    = (w_px >= 0) && (w_px < w_pfw) && (w_py >= 0) && (w_py < w_pfh);

    // Read data of both frame stores.
    logic [31:0] w_s_rdata, w_d_rdata;

    // Captured item.
    logic [1:0]           r_cmd, r_mode;
    logic [31:0]          r_pix_in;
    logic                 r_pix_ok;
    logic [AW-1:0]        r_pix_addr;
    logic signed [CW-1:0] r_sx, r_sy, r_dx, r_dy, r_cw, r_ch;
    logic signed [CW-1:0] r_i, r_j;
    logic [31:0]          r_res_pix;
    logic                 r_res_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_cmd      <= i_cmd;
            r_mode     <= i_blend_mode;
            r_pix_in   <= i_pixel_in;
            r_pix_ok   <= w_pok;
            r_pix_addr <= mk_addr(w_px, w_py);
            r_sx       <= w_sclip.x;
            r_sy       <= w_sclip.y;
            r_dx       <= w_dclip.x;
            r_dy       <= w_dclip.y;
            r_cw       <= (w_sclip.w < w_dclip.w) ? w_sclip.w : w_dclip.w;
            r_ch       <= (w_sclip.h < w_dclip.h) ? w_sclip.h : w_dclip.h;
            r_res_pix  <= '0;
            r_res_ok   <= (i_cmd == crob_pkg::CMD_BLIT) ? 1'b1 : w_pok;
        end else if (i_ctl.cap_rd) begin
            r_res_pix  <= r_pix_ok ? w_d_rdata : '0;
        end
    end

    // Blit walk.
    logic [AW-1:0] w_s_addr, w_d_addr;
    logic [AW-1:0] r_d_waddr;
    logic          w_col_end;
    assign w_s_addr  = mk_addr(r_sx + r_i, r_sy + r_j);
    assign w_d_addr  = mk_addr(r_dx + r_i, r_dy + r_j);
    assign w_col_end = (r_i == r_cw - CW'(1));

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_ctl.wr_blit) begin
            if (w_col_end) begin
                r_i <= '0;
                r_j <= r_j + CW'(1);
            end else begin
                r_i <= r_i + CW'(1);
            end
        end
        if (i_ctl.rd_blit) begin
            r_d_waddr <= w_d_addr;
        end
    end

    // Frame stores.
    logic        w_s_we, w_d_we;
    logic [31:0] w_d_wdata;

    assign w_s_we = i_ctl.wr_pix && r_pix_ok && (r_cmd == crob_pkg::CMD_WR_SRC);
    assign w_d_we = (i_ctl.wr_pix && r_pix_ok && (r_cmd == crob_pkg::CMD_WR_DST))
                    || i_ctl.wr_blit;

    crob_ram #(.WIDTH(32), .DEPTH(RDEP)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr ($clog2(RDEP)'(r_pix_addr)),
        .i_wdata (r_pix_in),
        .i_raddr ($clog2(RDEP)'(w_s_addr)),
        .o_rdata (w_s_rdata)
    );

    crob_ram #(.WIDTH(32), .DEPTH(RDEP)) u_dst_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr ($clog2(RDEP)'(i_ctl.wr_blit ? r_d_waddr : r_pix_addr)),
        .i_wdata (i_ctl.wr_blit ? w_d_wdata : r_pix_in),
        .i_raddr ($clog2(RDEP)'(i_ctl.rd_pix ? r_pix_addr : w_d_addr)),
        .o_rdata (w_d_rdata)
    );

    // Raster operation: products registered, then divide by 255 exactly
    // with floor(t/255) = (t + 1 + (t >> 8)) >> 8 for t below 65535.
    logic [31:0] r_s, r_d;
    logic [15:0] r_pa [3];
    logic [15:0] r_pb [3];

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_s <= w_s_rdata;
            r_d <= w_d_rdata;
            for (int c = 0; c < 3; c++) begin
                r_pa[c] <= (8'hFF - w_s_rdata[31:24]) * w_d_rdata[8*c +: 8];
                r_pb[c] <= w_s_rdata[31:24] * w_s_rdata[8*c +: 8];
            end
        end
    end

    logic [23:0] w_blend;
    always_comb begin
        logic [16:0] t;
        logic [16:0] q;
        w_blend = '0;
        for (int c = 0; c < 3; c++) begin
            t = 17'(r_pa[c]) + 17'(r_pb[c]);
            q = (t + 17'd1 + (t >> 8)) >> 8;
            w_blend[8*c +: 8] = q[7:0];
        end
    end

    always_comb begin
        case (r_mode)
            crob_pkg::MODE_COPY:  w_d_wdata = r_s;
            crob_pkg::MODE_XOR:   w_d_wdata = r_d ^ r_s;
            crob_pkg::MODE_BLEND: w_d_wdata = {r_d[31:24], w_blend};
            default:              w_d_wdata = {r_s[31:24], r_d[23:0]};
        endcase
    end

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_out_pix;
    logic        r_out_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_ctl.out_load) begin
            r_out_pix <= r_res_pix;
            r_out_ok  <= r_res_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_ok        = r_out_ok;

    assign o_sts.cmd      = r_cmd;
    assign o_sts.empty    = (r_cw == '0) || (r_ch == '0);
    assign o_sts.last     = w_col_end && (r_j == r_ch - CW'(1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

// ===== hw/rtl/clipped_raster_op_blitter_top.sv =====
// Items are handled one at a time: a new command transfer is taken only
// when the controller is back in idle, and the blit walk steps through
// each clipped pixel in turn with a read, a blend and a write step.
// Reset (synchronous, active low) clears the controller and the output valid
// flag and sets all four size registers to 256; frame contents stay undefined.
// ----------------------------------------------------------------------------
// clipped_raster_op_blitter_top
// 2D blitter with clipping and four raster operations over two RGBA frames.
// ----------------------------------------------------------------------------
module clipped_raster_op_blitter_top #(
    parameter int MAX_WIDTH  = crob_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crob_pkg::DEF_MAX_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    crob_cmd_if.sink      i_cmd,
    crob_res_if.source    o_res,
    crob_cfg_if.sink      i_cfg
);

    crob_pkg::t_ctl_cmd w_ctl;
    crob_pkg::t_ctl_sts w_sts;
    logic               w_in_ready;

    // Configuration writes are always taken; they land directly in the size
    // registers of the datapath.
    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = w_in_ready;

    // The controller accepts a command only when idle. The finished result
    // sits in the output register, so a new command transfer can follow
    // while the previous result still waits for its transfer out.
    crob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // The datapath clips on capture, holds both frame stores and walks the
    // clipped rectangle row by row.
    crob_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .i_cmd         (i_cmd.cmd),
        .i_dest_x      (i_cmd.dest_x),
        .i_dest_y      (i_cmd.dest_y),
        .i_src_x       (i_cmd.src_x),
        .i_src_y       (i_cmd.src_y),
        .i_rect_width  (i_cmd.rect_width),
        .i_rect_height (i_cmd.rect_height),
        .i_blend_mode  (i_cmd.blend_mode),
        .i_pixel_in    (i_cmd.pixel_in),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_pixel_out   (o_res.pixel_out),
        .o_ok          (o_res.ok)
    );

endmodule

// ===== hw/rtl/crob_checker.sv =====
// ----------------------------------------------------------------------------
// crob_checker
// Port-level checks of the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module crob_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_pixel_out,
    input logic        i_ok
);

    // A result that waits for its transfer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pixel_out))
        else $error("result dropped or changed while stalled");

    // A failed access never returns pixel data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ok |-> i_pixel_out == '0)
        else $error("pixel data shown on a failed access");

    // No result comes out of reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Configuration writes are never stalled.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port stalled");

endmodule

bind clipped_raster_op_blitter_top crob_checker u_crob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_pixel_out (o_res.pixel_out),
    .i_ok        (o_res.ok)
);

// ===== tb/sv/tb_clipped_raster_op_blitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clipped_raster_op_blitter_top
// Self-checking bench for the clipped raster-op blitter: a behavioral pixel
// model predicts every result, random traffic and handshake stalls exercise
// clipping, the four raster operations and the pixel accesses.
// ----------------------------------------------------------------------------
module tb_clipped_raster_op_blitter_top;

    localparam int FW         = 256;
    localparam int FH         = 256;
    localparam int WORDS      = FW * FH;
    localparam int CYCLE_CAP  = 10000000;
    localparam int MAX_AREA   = 300;
    localparam int SETTLE     = 8;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        logic signed [11:0] sx;
        logic signed [11:0] sy;
        logic signed [11:0] rw;
        logic signed [11:0] rh;
        logic [1:0]         mode;
        logic [31:0]        pix;
    } t_blit_item;

    typedef struct {
        logic [31:0] pixel;
        logic        ok;
    } t_pixel_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    crob_cmd_if cmd_ch();
    crob_res_if res_ch();
    crob_cfg_if cfg_ch();

    clipped_raster_op_blitter_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of both frames, with a flag per pixel telling whether it
    // has been written since reset.
    logic [31:0] src_pix [WORDS];
    logic [31:0] dst_pix [WORDS];
    bit          src_known [WORDS];
    bit          dst_known [WORDS];
    logic [8:0]  size_reg [4];

    t_pixel_result expected_results [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 25;
    int          recv_idle_pct = 50;
    int          hold_request = 0;

    function automatic int eff_size(logic [8:0] v, int max_v);
        if (v == 0) return 1;
        if (v > max_v) return max_v;
        return int'(v);
    endfunction

    function automatic void clip_rect(inout int x, inout int y, inout int w,
                                      inout int h, input int fw, input int fh);
        if (w < 0) begin x += w; w = -w; end
        if (h < 0) begin y += h; h = -h; end
        if (x < 0) begin w += x; if (w < 0) w = 0; x = 0; end
        if (y < 0) begin h += y; if (h < 0) h = 0; y = 0; end
        if (x >= fw) x = fw - 1;
        if (y >= fh) y = fh - 1;
        if (x + w > fw) w = fw - x;
        if (y + h > fh) h = fh - y;
    endfunction

    // Clipped blit geometry for the current sizes.
    function automatic void blit_geometry(input t_blit_item it, output int lx,
                                          output int ly, output int rx,
                                          output int ry, output int w,
                                          output int h);
        int rw, rh, lw, lh;
        rx = it.sx; ry = it.sy; rw = it.rw; rh = it.rh;
        lx = it.dx; ly = it.dy; lw = it.rw; lh = it.rh;
        clip_rect(rx, ry, rw, rh, eff_size(size_reg[crob_pkg::REG_SRC_W], FW),
                  eff_size(size_reg[crob_pkg::REG_SRC_H], FH));
        clip_rect(lx, ly, lw, lh, eff_size(size_reg[crob_pkg::REG_DEST_W], FW),
                  eff_size(size_reg[crob_pkg::REG_DEST_H], FH));
        w = (rw < lw) ? rw : lw;
        h = (rh < lh) ? rh : lh;
    endfunction

    function automatic logic [31:0] blend_rgb(logic [31:0] d, logic [31:0] s);
        logic [31:0] r;
        int a, v;
        a = s[31:24];
        r = {d[31:24], 24'd0};
        for (int c = 0; c < 3; c++) begin
            v = ((255 - a) * d[c*8 +: 8] + a * s[c*8 +: 8]) / 255;
            r[c*8 +: 8] = v[7:0];
        end
        return r;
    endfunction

    function automatic bit in_frame(int x, int y, int wr, int hr);
        return x >= 0 && y >= 0 && x < eff_size(size_reg[wr], FW) &&
               y < eff_size(size_reg[hr], FH);
    endfunction

    // An item is legal when it touches no pixel that was never written and
    // its blit walk stays short.
    function automatic bit item_legal(t_blit_item it);
        int lx, ly, rx, ry, w, h;
        if (it.cmd == crob_pkg::CMD_RD_DST) begin
            if (!in_frame(it.dx, it.dy, crob_pkg::REG_DEST_W, crob_pkg::REG_DEST_H))
                return 1;
            return dst_known[it.dy * FW + it.dx];
        end
        if (it.cmd != crob_pkg::CMD_BLIT) return 1;
        blit_geometry(it, lx, ly, rx, ry, w, h);
        if (w * h > MAX_AREA) return 0;
        for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++)
                if (!src_known[(ry + j) * FW + rx + i] ||
                    !dst_known[(ly + j) * FW + lx + i]) return 0;
        return 1;
    endfunction

    // Updates the shadow frames and returns the result the block must show.
    function automatic t_pixel_result apply_command(t_blit_item it);
        t_pixel_result r;
        int lx, ly, rx, ry, w, h, si, di;
        r.pixel = '0;
        r.ok = 1'b0;
        case (it.cmd)
            crob_pkg::CMD_WR_SRC: begin
                if (in_frame(it.sx, it.sy, crob_pkg::REG_SRC_W, crob_pkg::REG_SRC_H)) begin
                    src_pix[it.sy * FW + it.sx] = it.pix;
                    src_known[it.sy * FW + it.sx] = 1;
                    r.ok = 1'b1;
                end
            end
            crob_pkg::CMD_WR_DST: begin
                if (in_frame(it.dx, it.dy, crob_pkg::REG_DEST_W, crob_pkg::REG_DEST_H)) begin
                    dst_pix[it.dy * FW + it.dx] = it.pix;
                    dst_known[it.dy * FW + it.dx] = 1;
                    r.ok = 1'b1;
                end
            end
            crob_pkg::CMD_RD_DST: begin
                if (in_frame(it.dx, it.dy, crob_pkg::REG_DEST_W, crob_pkg::REG_DEST_H)) begin
                    r.pixel = dst_pix[it.dy * FW + it.dx];
                    r.ok = 1'b1;
                end
            end
            default: begin
                blit_geometry(it, lx, ly, rx, ry, w, h);
                for (int j = 0; j < h; j++) begin
                    for (int i = 0; i < w; i++) begin
                        si = (ry + j) * FW + rx + i;
                        di = (ly + j) * FW + lx + i;
                        case (it.mode)
                            crob_pkg::MODE_COPY:
                                dst_pix[di] = src_pix[si];
                            crob_pkg::MODE_XOR:
                                dst_pix[di] ^= src_pix[si];
                            crob_pkg::MODE_BLEND:
                                dst_pix[di] = blend_rgb(dst_pix[di], src_pix[si]);
                            default:
                                dst_pix[di] = {src_pix[si][31:24], dst_pix[di][23:0]};
                        endcase
                    end
                end
                r.ok = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    // Result checker: every transfer on the result channel is matched against
    // the oldest prediction.
    always @(posedge i_clk) begin
        t_pixel_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", res_ch.pixel_out, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (res_ch.pixel_out !== want.pixel)
                    report_mismatch("pixel_out", res_ch.pixel_out, want.pixel);
                if (res_ch.ok !== want.ok)
                    report_mismatch("ok", {31'd0, res_ch.ok}, {31'd0, want.ok});
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            res_ch.ready <= 1'b0;
            hold_request <= hold_request - 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(t_blit_item it);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= it.cmd;
        cmd_ch.dest_x      <= it.dx;
        cmd_ch.dest_y      <= it.dy;
        cmd_ch.src_x       <= it.sx;
        cmd_ch.src_y       <= it.sy;
        cmd_ch.rect_width  <= it.rw;
        cmd_ch.rect_height <= it.rh;
        cmd_ch.blend_mode  <= it.mode;
        cmd_ch.pixel_in    <= it.pix;
        do @(posedge i_clk); while (!cmd_ch.ready);
        expected_results.push_back(apply_command(it));
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(logic [1:0] idx, logic [8:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        size_reg[idx] = value;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(logic [8:0] dw, logic [8:0] dh, logic [8:0] sw,
                             logic [8:0] sh);
        wait_drained();
        write_size(crob_pkg::REG_DEST_W, dw);
        write_size(crob_pkg::REG_DEST_H, dh);
        write_size(crob_pkg::REG_SRC_W, sw);
        write_size(crob_pkg::REG_SRC_H, sh);
    endtask

    function automatic t_blit_item make_item(logic [1:0] c, int dx, int dy,
                                             int sx, int sy, int rw, int rh,
                                             logic [1:0] m, logic [31:0] p);
        t_blit_item it;
        it.cmd = c; it.dx = 12'(dx); it.dy = 12'(dy); it.sx = 12'(sx);
        it.sy = 12'(sy); it.rw = 12'(rw); it.rh = 12'(rh); it.mode = m;
        it.pix = p;
        return it;
    endfunction

    // Coordinate mostly near the used corner, sometimes near the far edge,
    // now and then anywhere in the 12-bit range.
    function automatic int rand_coord(logic [8:0] edge_reg);
        int k;
        k = $urandom_range(99);
        if (k < 70) return int'($urandom_range(28)) - 6;
        if (k < 90) return int'(edge_reg) + int'($urandom_range(6)) - 3;
        return int'($urandom_range(4095)) - 2048;
    endfunction

    function automatic int rand_extent();
        if ($urandom_range(99) < 85) return int'($urandom_range(36)) - 18;
        return int'($urandom_range(4095)) - 2048;
    endfunction

    function automatic t_blit_item random_item();
        t_blit_item it;
        it.cmd  = 2'($urandom_range(3));
        it.dx   = 12'(rand_coord(size_reg[crob_pkg::REG_DEST_W]));
        it.dy   = 12'(rand_coord(size_reg[crob_pkg::REG_DEST_H]));
        it.sx   = 12'(rand_coord(size_reg[crob_pkg::REG_SRC_W]));
        it.sy   = 12'(rand_coord(size_reg[crob_pkg::REG_SRC_H]));
        it.rw   = 12'(rand_extent());
        it.rh   = 12'(rand_extent());
        it.mode = 2'($urandom_range(3));
        it.pix  = $urandom();
        return it;
    endfunction

    // Draws until an item is legal; after many misses it falls back to a
    // pixel write, which is always legal.
    task automatic send_random(int count);
        t_blit_item it;
        int tries;
        for (int n = 0; n < count; n++) begin
            tries = 0;
            do begin
                it = random_item();
                tries++;
            end while (!item_legal(it) && tries < 40);
            if (!item_legal(it)) it.cmd = crob_pkg::CMD_WR_SRC;
            send_item(it);
        end
    endtask

    // Fill the top-left corner of both frames so later traffic has data.
    task automatic test_fill();
        for (int y = 0; y < 16; y++)
            for (int x = 0; x < 16; x++) begin
                send_item(make_item(crob_pkg::CMD_WR_SRC, 0, 0, x, y, 0, 0,
                                    crob_pkg::MODE_COPY, $urandom()));
                send_item(make_item(crob_pkg::CMD_WR_DST, x, y, 0, 0, 0, 0,
                                    crob_pkg::MODE_COPY, $urandom()));
            end
    endtask

    task automatic test_directed();
        set_sizes(9'd16, 9'd16, 9'd16, 9'd16);
        send_item(make_item(crob_pkg::CMD_WR_SRC, 0, 0, 15, 15, 0, 0,
                            crob_pkg::MODE_COPY, 32'hFFFF_FFFF));
        send_item(make_item(crob_pkg::CMD_WR_SRC, 0, 0, 16, 0, 0, 0,
                            crob_pkg::MODE_COPY, 32'h1234_5678));
        send_item(make_item(crob_pkg::CMD_WR_SRC, 0, 0, -2048, 2047, 0, 0,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_WR_DST, 0, 0, 0, 0, 0, 0,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_WR_DST, 2047, -1, 0, 0, 0, 0,
                            crob_pkg::MODE_COPY, 32'hFFFF_FFFF));
        send_item(make_item(crob_pkg::CMD_RD_DST, 0, 0, 0, 0, 0, 0,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_RD_DST, -2048, 0, 0, 0, 0, 0,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_RD_DST, 0, 16, 0, 0, 0, 0,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_BLIT, 1, 1, 2, 3, 4, 3,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_BLIT, 4, 4, 0, 0, 5, 5,
                            crob_pkg::MODE_XOR, 32'h0));
        send_item(make_item(crob_pkg::CMD_BLIT, 2, 6, 7, 1, 6, 4,
                            crob_pkg::MODE_BLEND, 32'h0));
        send_item(make_item(crob_pkg::CMD_BLIT, 8, 2, 3, 9, 3, 6,
                            crob_pkg::MODE_ALPHA, 32'h0));
        // Negative sizes extend left and up from the origin.
        send_item(make_item(crob_pkg::CMD_BLIT, 10, 10, 12, 9, -4, -3,
                            crob_pkg::MODE_XOR, 32'h0));
        // Negative origin eats into the size.
        send_item(make_item(crob_pkg::CMD_BLIT, -3, -2, 1, 1, 6, 5,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_BLIT, 3, 3, -2048, -2048, 5, 5,
                            crob_pkg::MODE_COPY, 32'h0));
        // Origin past the edge pins to the last column and row.
        send_item(make_item(crob_pkg::CMD_BLIT, 2047, 2047, 0, 0, 4, 4,
                            crob_pkg::MODE_BLEND, 32'h0));
        send_item(make_item(crob_pkg::CMD_BLIT, 5, 5, 40, 300, 3, 3,
                            crob_pkg::MODE_ALPHA, 32'h0));
        // Empty blit.
        send_item(make_item(crob_pkg::CMD_BLIT, 5, 5, 5, 5, 0, 7,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_BLIT, 0, 0, 0, 0, 2047, 2047,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_RD_DST, 15, 15, 0, 0, 0, 0,
                            crob_pkg::MODE_COPY, 32'h0));
        send_item(make_item(crob_pkg::CMD_RD_DST, 7, 4, 0, 0, 0, 0,
                            crob_pkg::MODE_COPY, 32'h0));
    endtask

    task automatic test_random_settings();
        send_idle_pct = 25; recv_idle_pct = 50;
        set_sizes(9'd12, 9'd9, 9'd16, 9'd5);
        send_random(120);
        set_sizes(9'd1, 9'd1, 9'd1, 9'd1);
        send_random(60);
        send_idle_pct = 50; recv_idle_pct = 25;
        set_sizes(9'd0, 9'd511, 9'd300, 9'd0);
        send_random(100);
        set_sizes(9'd16, 9'd16, 9'd16, 9'd16);
        send_random(120);
        send_idle_pct = 0; recv_idle_pct = 0;
        set_sizes(9'd256, 9'd256, 9'd256, 9'd256);
        send_random(120);
        set_sizes(9'd16, 9'd14, 9'd13, 9'd16);
        send_random(150);
    endtask

    // Long receiver hold-off while the sender keeps offering, then a pause
    // until every result has come back.
    task automatic test_backpressure();
        hold_request <= 400;
        send_random(30);
        wait_drained();
        send_random(40);
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = crob_pkg::CMD_WR_SRC;
        cmd_ch.dest_x = '0;
        cmd_ch.dest_y = '0;
        cmd_ch.src_x = '0;
        cmd_ch.src_y = '0;
        cmd_ch.rect_width = '0;
        cmd_ch.rect_height = '0;
        cmd_ch.blend_mode = crob_pkg::MODE_COPY;
        cmd_ch.pixel_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = crob_pkg::REG_DEST_W;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        for (int k = 0; k < 4; k++) size_reg[k] = 9'd256;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill();
        test_directed();
        test_random_settings();
        test_backpressure();
        wait_drained();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/crob_pkg.sv
hw/rtl/crob_cmd_if.sv
hw/rtl/crob_res_if.sv
hw/rtl/crob_cfg_if.sv
hw/rtl/crob_ram.sv
hw/rtl/crob_ctrl.sv
hw/rtl/crob_datapath.sv
hw/rtl/clipped_raster_op_blitter_top.sv
hw/rtl/crob_checker.sv
tb/sv/tb_clipped_raster_op_blitter_top.sv
